// ----- rtl/core/nec_ir_pulse_decoder_defines.svh -----
// Assertion macros for the NEC IR pulse decoder RTL.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef NEC_IR_PULSE_DECODER_DEFINES_SVH
`define NEC_IR_PULSE_DECODER_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define NIRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger
`define NIRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/nirp_pkg.sv -----
// Shared types, codes and threshold arithmetic of the NEC IR pulse decoder.
// No dependencies; used by every module of the block.
package nirp_pkg;

    localparam int DUR_W   = 32;
    localparam int THR_W   = 29;
    localparam int UNIT_W  = 24;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [UNIT_W-1:0] UNIT_RESET    = 24'd562500;
    localparam logic [2:0]        LP_THR_RESET  = 3'd5;

    // Result kinds
    localparam logic [2:0] EV_ERROR   = 3'd0;
    localparam logic [2:0] EV_KEYUP   = 3'd1;
    localparam logic [2:0] EV_KEYDOWN = 3'd2;
    localparam logic [2:0] EV_LONG    = 3'd3;
    localparam logic [2:0] EV_REPEAT  = 3'd4;

    // Result queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic [THR_W-1:0] thr_val_t;

    // Exclusive window bounds derived from the protocol unit
    typedef struct packed {
        thr_val_t hdr16_lo;
        thr_val_t hdr16_hi;
        thr_val_t hdr8_lo;
        thr_val_t hdr8_hi;
        thr_val_t hsp_lo;
        thr_val_t hsp_hi;
        thr_val_t rsp_lo;
        thr_val_t rsp_hi;
        thr_val_t one_lo;
        thr_val_t one_hi;
        thr_val_t three_lo;
        thr_val_t three_hi;
        thr_val_t trl_lo;
    } thr_t;

    typedef struct packed {
        logic [15:0] user_code;
        logic        check_user_code;
        logic [2:0]  lp_thr;
        thr_t        thr;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] key;
        logic       restart;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] num;
        res_t       r0;
        res_t       r1;
    } push_t;

    typedef struct packed {
        logic two_free;
    } room_t;

    // Work out all window bounds with shifts and adds
    function automatic thr_t calc_thr(input logic [UNIT_W-1:0] u);
        thr_val_t uu;
        thr_val_t hh;
        thr_t     t;
        uu = THR_W'(u);
        hh = THR_W'(u >> 1);
        t.hdr16_lo = (uu << 4) - (uu << 1);
        t.hdr16_hi = (uu << 4) + (uu << 1);
        t.hdr8_lo  = (uu << 3) - hh;
        t.hdr8_hi  = (uu << 3) + hh;
        t.hsp_lo   = (uu << 3) - uu;
        t.hsp_hi   = (uu << 3) + uu;
        t.rsp_lo   = (uu << 2) - hh;
        t.rsp_hi   = (uu << 2) + hh;
        t.one_lo   = uu - hh;
        t.one_hi   = uu + hh;
        t.three_lo = (uu << 1) + uu - hh;
        t.three_hi = (uu << 1) + uu + hh;
        t.trl_lo   = (uu << 3) + (uu << 1) - hh;
        return t;
    endfunction

    localparam thr_t THR_RESET = calc_thr(UNIT_RESET);

    // Strictly between two bounds
    function automatic logic in_window(input logic [DUR_W-1:0] d,
                                       input thr_val_t lo, input thr_val_t hi);
        return (d > {{(DUR_W-THR_W){1'b0}}, lo}) && (d < {{(DUR_W-THR_W){1'b0}}, hi});
    endfunction

endpackage

// ----- rtl/core/nec_ir_pulse_decoder.sv -----
// NEC IR pulse decoder: top level joining registers, front end and back end.
// Depends on nirp_pkg, nirp_regs, nirp_front and nirp_back.
//
// Use: each input transaction carries one measured pulse or space
// (action 0, is_pulse, duration_ns) or a release-timer expiry (action 1).
// Output transactions carry decoded events: protocol error, key up, key
// down, long press or repeat counted, with key_code, restart_timer and
// last_of_run marking the final result caused by one input.
// Both channels use valid/ready. The APB port sets the unit length, user
// code, user code check and long press threshold; pready is always high.
// Timing: an input is classified and the state updated in the cycle it is
// accepted; its results enter a four-entry queue at that edge and, if the queue
// was empty, the first one is offered on the output from the next cycle.
// One input is taken every cycle while the queue has two free entries;
// results leave at one per cycle, set by the single output port.
// When the receiver stalls the queue fills and in_ready drops once fewer
// than two entries are free; nothing is lost.
// Reset clears the decoder to idle, empties the queue, sets no previous key,
// enables key acceptance and loads the default 562500 ns unit.
module nec_ir_pulse_decoder #(
    parameter int FRAME_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nirp_pkg::PADDR_W-1:0]  paddr,
    input  logic [nirp_pkg::PDATA_W-1:0]  pwdata,
    output logic [nirp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic                          is_pulse,
    input  logic [nirp_pkg::DUR_W-1:0]    duration_ns,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    event_kind,
    output logic [7:0]                    key_code,
    output logic                          restart_timer,
    output logic                          last_of_run
);
    import nirp_pkg::*;

    cfg_t  cfg;
    room_t room;
    push_t push;

    // Configuration registers
    nirp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Edge classification and frame state machine
    nirp_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .is_pulse    (is_pulse),
        .duration_ns (duration_ns),
        .cfg         (cfg),
        .room        (room),
        .push        (push)
    );

    // Result queue and output channel
    nirp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .room          (room),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .key_code      (key_code),
        .restart_timer (restart_timer),
        .last_of_run   (last_of_run)
    );

endmodule

// ----- rtl/core/nirp_regs.sv -----
// APB configuration registers of the NEC IR pulse decoder.
// Depends on nirp_pkg; precomputes the timing windows on each unit write.
module nirp_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nirp_pkg::PADDR_W-1:0]  paddr,
    input  logic [nirp_pkg::PDATA_W-1:0]  pwdata,
    output logic [nirp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output nirp_pkg::cfg_t                cfg
);
    import nirp_pkg::*;

    localparam logic [1:0] REG_UNIT  = 2'd0;
    localparam logic [1:0] REG_USER  = 2'd1;
    localparam logic [1:0] REG_CHECK = 2'd2;
    localparam logic [1:0] REG_LPTHR = 2'd3;

    logic [UNIT_W-1:0] unit_reg;
    logic [15:0]       user_reg;
    logic              check_reg;
    logic [2:0]        lpt_reg;
    thr_t              thr_reg;
    logic              wr_en;
    logic [1:0]        idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    // Write registers; windows follow the written unit at the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg  <= UNIT_RESET;
            user_reg  <= '0;
            check_reg <= 1'b0;
            lpt_reg   <= LP_THR_RESET;
            thr_reg   <= THR_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_UNIT:
                begin
                    unit_reg <= pwdata[UNIT_W-1:0];
                    thr_reg  <= calc_thr(pwdata[UNIT_W-1:0]);
                end
                REG_USER:  user_reg  <= pwdata[15:0];
                REG_CHECK: check_reg <= pwdata[0];
                REG_LPTHR: lpt_reg   <= pwdata[2:0];
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_UNIT:  prdata = {{(PDATA_W-UNIT_W){1'b0}}, unit_reg};
            REG_USER:  prdata = {16'h0000, user_reg};
            REG_CHECK: prdata = {31'h0, check_reg};
            REG_LPTHR: prdata = {29'h0, lpt_reg};
        endcase
    end

    assign cfg.user_code       = user_reg;
    assign cfg.check_user_code = check_reg;
    assign cfg.lp_thr          = lpt_reg;
    assign cfg.thr             = thr_reg;

endmodule

// ----- rtl/core/nirp_front.sv -----
// Front end of the NEC IR pulse decoder: takes edges, runs the frame state
// machine and pushes up to two results a transaction. Depends on nirp_pkg.
`include "nec_ir_pulse_decoder_defines.svh"

module nirp_front #(
    parameter int FRAME_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic                        is_pulse,
    input  logic [nirp_pkg::DUR_W-1:0]  duration_ns,
    input  nirp_pkg::cfg_t              cfg,
    input  nirp_pkg::room_t             room,
    output nirp_pkg::push_t             push
);
    import nirp_pkg::*;

    localparam int               BC_W    = $clog2(FRAME_BITS + 1);
    localparam logic [BC_W-1:0]  BC_ONE  = BC_W'(1);
    localparam logic [BC_W-1:0]  BC_LAST = BC_W'(FRAME_BITS);
    localparam logic [7:0]       KEY_NONE = 8'hff;

    localparam logic [2:0] PH_INACTIVE  = 3'd0;
    localparam logic [2:0] PH_HDR_SPACE = 3'd1;
    localparam logic [2:0] PH_BIT_PULSE = 3'd2;
    localparam logic [2:0] PH_BIT_SPACE = 3'd3;
    localparam logic [2:0] PH_TRL_PULSE = 3'd4;
    localparam logic [2:0] PH_TRL_SPACE = 3'd5;

    logic [2:0]      phase_reg,  phase_next;
    logic [BC_W-1:0] bc_reg,     bc_next;
    logic [31:0]     shift_reg,  shift_next;
    logic            vx_reg,     vx_next;
    logic            rf_reg,     rf_next;
    logic [7:0]      held_reg,   held_next;
    logic [7:0]      prev_reg,   prev_next;
    logic            accept_reg, accept_next;
    logic [2:0]      press_reg,  press_next;

    logic            in_fire;
    logic            edge_ok;
    push_t           push_d;
    logic [BC_W-1:0] bc_inc;

    logic w_hdr16, w_hdr8, w_hsp, w_rsp, w_one, w_three, ge_trl;
    logic [7:0]  f_a, f_na, f_c, f_nc;
    logic        f_ext;
    logic [15:0] f_sc_hi;
    logic [7:0]  f_key;
    logic        f_acc;

    assign in_ready = room.two_free;
    assign in_fire  = in_valid && in_ready;
    assign bc_inc   = bc_reg + BC_ONE;

    // Classify the duration against every window
    assign w_hdr16 = in_window(duration_ns, cfg.thr.hdr16_lo, cfg.thr.hdr16_hi);
    assign w_hdr8  = in_window(duration_ns, cfg.thr.hdr8_lo,  cfg.thr.hdr8_hi);
    assign w_hsp   = in_window(duration_ns, cfg.thr.hsp_lo,   cfg.thr.hsp_hi);
    assign w_rsp   = in_window(duration_ns, cfg.thr.rsp_lo,   cfg.thr.rsp_hi);
    assign w_one   = in_window(duration_ns, cfg.thr.one_lo,   cfg.thr.one_hi);
    assign w_three = in_window(duration_ns, cfg.thr.three_lo, cfg.thr.three_hi);
    assign ge_trl  = duration_ns > {{(DUR_W-THR_W){1'b0}}, cfg.thr.trl_lo};

    // Frame kind, key and user code check of the collected word
    assign f_a     = shift_reg[31:24];
    assign f_na    = shift_reg[23:16];
    assign f_c     = shift_reg[15:8];
    assign f_nc    = shift_reg[7:0];
    assign f_ext   = ((f_c ^ f_nc) == 8'hff) && ((f_a ^ f_na) != 8'hff);
    assign f_sc_hi = f_ext ? {8'h00, f_a} : shift_reg[31:16];
    assign f_key   = f_ext ? f_na : f_c;
    assign f_acc   = accept_reg && !(cfg.check_user_code && (f_sc_hi != cfg.user_code));

    // Next state and results
    always_comb
    begin
        phase_next  = phase_reg;
        bc_next     = bc_reg;
        shift_next  = shift_reg;
        vx_next     = vx_reg;
        rf_next     = rf_reg;
        held_next   = held_reg;
        prev_next   = prev_reg;
        accept_next = accept_reg;
        press_next  = press_reg;
        edge_ok     = 1'b0;
        push_d      = '0;

        if (action)
        begin
            // Release timer: restore acceptance, drop the press count
            press_next  = '0;
            accept_next = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_INACTIVE:
                begin
                    if (is_pulse && (w_hdr16 || w_hdr8))
                    begin
                        if (w_hdr16)
                        begin
                            vx_next = 1'b0;
                            rf_next = 1'b0;
                        end
                        else
                        begin
                            vx_next = 1'b1;
                        end
                        bc_next    = '0;
                        phase_next = PH_HDR_SPACE;
                        edge_ok    = 1'b1;
                    end
                end
                PH_HDR_SPACE:
                begin
                    if (!is_pulse && w_hsp)
                    begin
                        phase_next = PH_BIT_PULSE;
                        edge_ok    = 1'b1;
                    end
                    else if (!is_pulse && w_rsp)
                    begin
                        rf_next    = 1'b1;
                        phase_next = PH_TRL_PULSE;
                        edge_ok    = 1'b1;
                    end
                end
                PH_BIT_PULSE:
                begin
                    if (is_pulse && w_one)
                    begin
                        phase_next = PH_BIT_SPACE;
                        edge_ok    = 1'b1;
                    end
                end
                PH_BIT_SPACE:
                begin
                    if (!is_pulse)
                    begin
                        if (rf_reg && (bc_reg == BC_ONE) && ge_trl)
                        begin
                            // Extended repeat ends after its single bit
                            phase_next = PH_INACTIVE;
                            edge_ok    = 1'b1;
                        end
                        else
                        begin
                            if (bc_reg > BC_ONE)
                            begin
                                rf_next = 1'b0;
                            end
                            shift_next = {shift_reg[30:0], w_three};
                            if (w_three || w_one)
                            begin
                                bc_next    = bc_inc;
                                phase_next = (bc_inc == BC_LAST) ? PH_TRL_PULSE
                                                                 : PH_BIT_PULSE;
                                edge_ok    = 1'b1;
                            end
                        end
                    end
                end
                PH_TRL_PULSE:
                begin
                    if (is_pulse && w_one)
                    begin
                        phase_next = PH_TRL_SPACE;
                        edge_ok    = 1'b1;
                    end
                end
                PH_TRL_SPACE:
                begin
                    if (!is_pulse && ge_trl)
                    begin
                        phase_next = PH_INACTIVE;
                        bc_next    = '0;
                        edge_ok    = 1'b1;
                        if (rf_reg)
                        begin
                            // Repeat frame: count or report long press
                            if (accept_reg)
                            begin
                                push_d.num        = 2'd1;
                                push_d.r0.key     = held_reg;
                                push_d.r0.restart = 1'b1;
                                push_d.r0.last    = 1'b1;
                                if (press_reg < cfg.lp_thr)
                                begin
                                    press_next     = press_reg + 3'd1;
                                    push_d.r0.kind = EV_REPEAT;
                                end
                                else
                                begin
                                    push_d.r0.kind = EV_LONG;
                                    prev_next      = held_reg;
                                end
                            end
                        end
                        else
                        begin
                            // Full frame: new key, key up of the old one first
                            if (vx_reg)
                            begin
                                rf_next = 1'b1;
                            end
                            accept_next = f_acc;
                            held_next   = f_key;
                            if (f_acc)
                            begin
                                prev_next = f_key;
                                if ((prev_reg != f_key) && (prev_reg != KEY_NONE))
                                begin
                                    push_d.num        = 2'd2;
                                    push_d.r0.kind    = EV_KEYUP;
                                    push_d.r0.key     = prev_reg;
                                    push_d.r0.restart = 1'b0;
                                    push_d.r0.last    = 1'b0;
                                    push_d.r1.kind    = EV_KEYDOWN;
                                    push_d.r1.key     = f_key;
                                    push_d.r1.restart = 1'b1;
                                    push_d.r1.last    = 1'b1;
                                end
                                else
                                begin
                                    push_d.num        = 2'd1;
                                    push_d.r0.kind    = EV_KEYDOWN;
                                    push_d.r0.key     = f_key;
                                    push_d.r0.restart = 1'b1;
                                    push_d.r0.last    = 1'b1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    edge_ok = 1'b0;
                end
            endcase

            // Protocol error: report and fall back to idle
            if (!edge_ok)
            begin
                phase_next        = PH_INACTIVE;
                bc_next           = '0;
                push_d            = '0;
                push_d.num        = 2'd1;
                push_d.r0.kind    = EV_ERROR;
                push_d.r0.last    = 1'b1;
            end
        end
    end

    assign push.num = in_fire ? push_d.num : 2'd0;
    assign push.r0  = push_d.r0;
    assign push.r1  = push_d.r1;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_INACTIVE;
            bc_reg     <= '0;
            shift_reg  <= '0;
            vx_reg     <= 1'b0;
            rf_reg     <= 1'b0;
            held_reg   <= '0;
            prev_reg   <= KEY_NONE;
            accept_reg <= 1'b1;
            press_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            bc_reg     <= bc_next;
            shift_reg  <= shift_next;
            vx_reg     <= vx_next;
            rf_reg     <= rf_next;
            held_reg   <= held_next;
            prev_reg   <= prev_next;
            accept_reg <= accept_next;
            press_reg  <= press_next;
        end
    end

    `NIRP_ASSERT_NOW(a_push_needs_fire, (push.num != 2'd0), in_fire, "push without transaction")
    `NIRP_ASSERT_NOW(a_pair_from_frame, (push.num == 2'd2), (phase_reg == PH_TRL_SPACE && !rf_reg && push.r1.last && !push.r0.last), "result pair outside frame end")
    `NIRP_ASSERT_NOW(a_single_is_last, (push.num == 2'd1), push.r0.last, "single result not marked last")
    `NIRP_ASSERT_NEXT(a_error_to_idle, (in_fire && !action && !edge_ok), (phase_reg == PH_INACTIVE && bc_reg == '0), "error did not return to idle")

endmodule

// ----- rtl/core/nirp_back.sv -----
// Back end of the NEC IR pulse decoder: result queue and output channel.
// Depends on nirp_pkg; takes up to two results a cycle, gives one.
`include "nec_ir_pulse_decoder_defines.svh"

module nirp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  nirp_pkg::push_t   push,
    output nirp_pkg::room_t   room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        event_kind,
    output logic [7:0]        key_code,
    output logic              restart_timer,
    output logic              last_of_run
);
    import nirp_pkg::*;

    res_t            q_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, rd_reg;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            pop;
    logic [Q_AW-1:0] wr_second;
    res_t            head;

    assign pop       = out_valid && out_ready;
    assign wr_second = wr_reg + Q_AW'(1);
    assign count_next = count_reg + Q_CW'(push.num) - Q_CW'(pop);

    assign room.two_free = count_reg <= Q_CW'(Q_DEPTH - 2);

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            q_reg[wr_reg] <= push.r0;
        end
        if (push.num == 2'd2)
        begin
            q_reg[wr_second] <= push.r1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + Q_AW'(push.num);
            rd_reg    <= rd_reg + Q_AW'(pop);
            count_reg <= count_next;
        end
    end

    // Present the head entry
    assign head          = q_reg[rd_reg];
    assign out_valid     = count_reg != '0;
    assign event_kind    = head.kind;
    assign key_code      = head.key;
    assign restart_timer = head.restart;
    assign last_of_run   = head.last;

    `NIRP_ASSERT_NOW(a_count_bound, 1'b1, (count_reg <= Q_CW'(Q_DEPTH)), "queue occupancy beyond depth")
    `NIRP_ASSERT_NOW(a_push_has_room, (push.num != 2'd0), (count_reg <= Q_CW'(Q_DEPTH - 2)), "push into a full queue")
    `NIRP_ASSERT_NEXT(a_empty_fill_shows, (count_reg == '0 && push.num != 2'd0), out_valid, "pushed result not presented")

endmodule
